// ===== hw/rtl/weighted_priority_chunk_dispatcher_unit_macros.svh =====
// Assertion macros used by the dispatcher datapath.
`ifndef WEIGHTED_PRIORITY_CHUNK_DISPATCHER_UNIT_MACROS_SVH
`define WEIGHTED_PRIORITY_CHUNK_DISPATCHER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define WPCD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dispatcher assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define WPCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dispatcher assertion failed");

`endif

// ===== hw/rtl/wpcd_pkg.sv =====
// Shared constants, codes, control structures and the weight cycle of the dispatcher.
package wpcd_pkg;

  localparam int JOBS_DEFAULT  = 8;
  localparam int LANES_DEFAULT = 16;
  localparam int CYCLE_LEN     = 7;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 72;

  // Input kinds.
  localparam logic [1:0] KIND_SUBMIT   = 2'd0;
  localparam logic [1:0] KIND_REQUEST  = 2'd1;
  localparam logic [1:0] KIND_COMPLETE = 2'd2;
  localparam logic [1:0] KIND_CANCEL   = 2'd3;

  // Result kinds.
  localparam logic [1:0] RES_NO_WORK = 2'd0;
  localparam logic [1:0] RES_GRANT   = 2'd1;
  localparam logic [1:0] RES_DONE    = 2'd2;

  // Priorities.
  localparam logic [1:0] PRIO_LOW    = 2'd0;
  localparam logic [1:0] PRIO_NORMAL = 2'd1;
  localparam logic [1:0] PRIO_HIGH   = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WORKERS = 2'd0;
  localparam logic [1:0] CFG_GRAIN   = 2'd1;

  localparam logic [4:0]  WORKERS_RESET = 5'd16;
  localparam logic [15:0] GRAIN_RESET   = 16'd4;

  // Datapath commands.
  localparam logic [3:0] CMD_NONE     = 4'd0;
  localparam logic [3:0] CMD_LOAD     = 4'd1;
  localparam logic [3:0] CMD_SUBMIT   = 4'd2;
  localparam logic [3:0] CMD_COMPLETE = 4'd3;
  localparam logic [3:0] CMD_CANCEL   = 4'd4;
  localparam logic [3:0] CMD_ENQ      = 4'd5;
  localparam logic [3:0] CMD_REQUEUE  = 4'd6;
  localparam logic [3:0] CMD_FINISH   = 4'd7;
  localparam logic [3:0] CMD_PRI      = 4'd8;
  localparam logic [3:0] CMD_SCAN     = 4'd9;
  localparam logic [3:0] CMD_PICK     = 4'd10;
  localparam logic [3:0] CMD_GRANT    = 4'd11;
  localparam logic [3:0] CMD_NO_WORK  = 4'd12;
  localparam logic [3:0] CMD_DONE_ERR = 4'd13;
  localparam logic [3:0] CMD_DONE_OK  = 4'd14;
  localparam logic [3:0] CMD_EMIT     = 4'd15;

  typedef struct packed {
    logic [3:0] op;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       job_ok;
    logic       active;
    logic       prio_bad;
    logic       range_empty;
    logic       lane_ok;
    logic       finish_now;
    logic       total_nz;
    logic       pri_nz;
    logic       scan_hit;
    logic       checks_ok;
    logic       out_free;
  } dp_stat_t;

  // Weighted cycle: four high, two normal, one low.
  function automatic logic [1:0] weight_at(input logic [2:0] p);
    logic [1:0] w;
    case (p)
      3'd0, 3'd1, 3'd2, 3'd3: w = PRIO_HIGH;
      3'd4, 3'd5:             w = PRIO_NORMAL;
      default:                w = PRIO_LOW;
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/wpcd_ctrl.sv =====
// Controller state machine of the dispatcher: sequences datapath commands per item.
module wpcd_ctrl #(
  parameter int JOBS = wpcd_pkg::JOBS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  wpcd_pkg::dp_stat_t stat,
  output wpcd_pkg::dp_cmd_t  cmd
);
  import wpcd_pkg::*;

  localparam int GW = $clog2(3 * JOBS + 2);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_ENQ    = 4'd2;
  localparam logic [3:0] S_REQ    = 4'd3;
  localparam logic [3:0] S_FIN    = 4'd4;
  localparam logic [3:0] S_PRI    = 4'd5;
  localparam logic [3:0] S_SCAN   = 4'd6;
  localparam logic [3:0] S_PICK   = 4'd7;
  localparam logic [3:0] S_CHECK  = 4'd8;
  localparam logic [3:0] S_GENQ   = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [3:0]    state, state_next;
  logic [GW-1:0] guard, guard_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      guard <= '0;
    end else begin
      state <= state_next;
      guard <= guard_next;
    end
  end

  always_comb begin
    state_next = state;
    guard_next = guard;
    cmd.op     = CMD_NONE;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.op     = CMD_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        guard_next = '0;
        if (stat.kind == KIND_REQUEST) begin
          if (stat.total_nz) begin
            state_next = S_PRI;
          end else begin
            cmd.op     = CMD_NO_WORK;
            state_next = S_EMIT;
          end
        end else if (!stat.job_ok) begin
          state_next = S_IDLE;
        end else if (stat.kind == KIND_SUBMIT) begin
          if (stat.active) begin
            state_next = S_IDLE;
          end else if (stat.prio_bad) begin
            cmd.op     = CMD_DONE_ERR;
            state_next = S_EMIT;
          end else if (stat.range_empty) begin
            cmd.op     = CMD_DONE_OK;
            state_next = S_EMIT;
          end else begin
            cmd.op     = CMD_SUBMIT;
            state_next = S_ENQ;
          end
        end else if (!stat.active) begin
          state_next = S_IDLE;
        end else if (stat.kind == KIND_COMPLETE) begin
          if (stat.lane_ok) begin
            cmd.op     = CMD_COMPLETE;
            state_next = S_REQ;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          cmd.op     = CMD_CANCEL;
          state_next = S_REQ;
        end
      end
      S_ENQ: begin
        cmd.op     = CMD_ENQ;
        state_next = S_IDLE;
      end
      S_REQ: begin
        cmd.op     = CMD_REQUEUE;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (stat.finish_now) begin
          cmd.op     = CMD_FINISH;
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_PRI: begin
        cmd.op = CMD_PRI;
        if (stat.pri_nz) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.op = CMD_SCAN;
        if (stat.scan_hit) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        cmd.op     = CMD_PICK;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.checks_ok) begin
          cmd.op     = CMD_GRANT;
          state_next = S_GENQ;
        end else if (guard >= GW'(3 * JOBS) || !stat.total_nz) begin
          cmd.op     = CMD_NO_WORK;
          state_next = S_EMIT;
        end else begin
          guard_next = guard + GW'(1);
          state_next = S_PRI;
        end
      end
      S_GENQ: begin
        cmd.op     = CMD_ENQ;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.op     = CMD_EMIT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/wpcd_datapath.sv =====
// Datapath of the dispatcher: job table, ready queues, weight cycle and result register.
module wpcd_datapath #(
  parameter int JOBS  = wpcd_pkg::JOBS_DEFAULT,
  parameter int LANES = wpcd_pkg::LANES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  wpcd_pkg::dp_cmd_t  cmd,
  output wpcd_pkg::dp_stat_t stat,
  input  logic [1:0]         item_kind,
  input  logic [2:0]         item_job,
  input  logic [1:0]         item_prio,
  input  logic [63:0]        item_group,
  input  logic [31:0]        item_rs,
  input  logic [31:0]        item_re,
  input  logic [3:0]         item_lane,
  input  logic               item_cflag,
  input  logic               item_fflag,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_kind,
  output logic [2:0]         out_job,
  output logic [31:0]        out_b,
  output logic [31:0]        out_e,
  output logic [3:0]         out_lane,
  output logic               out_status
);
  import wpcd_pkg::*;
  `include "weighted_priority_chunk_dispatcher_unit_macros.svh"

  localparam int JW  = (JOBS > 1) ? $clog2(JOBS) : 1;
  localparam int CW  = $clog2(JOBS + 1);
  localparam int LW  = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int LCW = $clog2(LANES + 1);

  logic [4:0]  workers;
  logic [15:0] grain;

  logic [1:0]  in_kind, in_prio;
  logic [2:0]  in_job;
  logic [63:0] in_grp;
  logic [31:0] in_rs, in_re;
  logic [3:0]  in_lane;
  logic        in_cflag, in_fflag;

  logic [1:0]       j_prio  [JOBS];
  logic [63:0]      j_grp   [JOBS];
  logic [31:0]      j_next  [JOBS];
  logic [31:0]      j_end   [JOBS];
  logic [LCW-1:0]   j_lanes [JOBS];
  logic [LCW-1:0]   j_act   [JOBS];
  logic [LANES-1:0] j_busy  [JOBS];
  logic [JOBS-1:0]  f_act, f_q, f_can, f_fail;

  logic [JW-1:0] rl [3][JOBS];
  logic [CW-1:0] rc [3];
  logic [63:0]   lg [3];
  logic [2:0]    pos;
  logic [1:0]    sel_p;
  logic [JW-1:0] scan_idx;
  logic [JW-1:0] cur;

  logic [1:0]  res_kind;
  logic [2:0]  res_job;
  logic [31:0] res_b, res_e;
  logic [3:0]  res_lane;
  logic        res_status;

  logic [JW-1:0]  entry, rd;
  logic [63:0]    r_grp;
  logic           mismatch, last_idx, err_cur, enq_ok;
  logic [1:0]     dq_p, enq_p;
  logic           dq_found, fl_found;
  logic [JW-1:0]  dq_k, rm_k;
  logic [LW-1:0]  fl, lane_sel;
  logic           rm_en;
  logic [1:0]     rm_p;
  logic [15:0]    cs_eff;
  logic [32:0]    e_sum;
  logic [31:0]    e_min, items, wc32, lanes32;
  logic [4:0]     wc_eff;

  always_comb begin
    entry    = rl[sel_p][scan_idx];
    rd       = (cmd.op == CMD_SCAN || cmd.op == CMD_PICK) ? entry : cur;
    r_grp    = j_grp[rd];
    mismatch = r_grp != lg[sel_p];
    last_idx = (CW'(scan_idx) + CW'(1)) == rc[sel_p];
    err_cur  = f_can[cur] | f_fail[cur];
    enq_p    = j_prio[cur];
    enq_ok   = f_act[cur] && !f_q[cur] && !err_cur && (j_next[cur] < j_end[cur]) &&
               (j_act[cur] < j_lanes[cur]) && (rc[enq_p] < CW'(JOBS));

    // Position of this job in its ready queue, for removal on cancel or failure.
    dq_p     = j_prio[cur];
    dq_found = 1'b0;
    dq_k     = '0;
    for (int i = JOBS - 1; i >= 0; i--) begin
      if ((CW'(i) < rc[dq_p]) && (rl[dq_p][i] == cur)) begin
        dq_found = 1'b1;
        dq_k     = JW'(i);
      end
    end

    rm_en = 1'b0;
    rm_p  = dq_p;
    rm_k  = dq_k;
    if (cmd.op == CMD_PICK) begin
      rm_en = 1'b1;
      rm_p  = sel_p;
      rm_k  = scan_idx;
    end else if (cmd.op == CMD_REQUEUE && err_cur && f_q[cur] && dq_found) begin
      rm_en = 1'b1;
    end

    // Lowest free lane of the current job.
    fl_found = 1'b0;
    fl       = '0;
    for (int i = LANES - 1; i >= 0; i--) begin
      if (!j_busy[cur][i] && (LCW'(i) < j_lanes[cur])) begin
        fl_found = 1'b1;
        fl       = LW'(i);
      end
    end

    cs_eff = (grain == 16'd0) ? 16'd1 : grain;
    e_sum  = {1'b0, j_next[cur]} + 33'(cs_eff);
    e_min  = (e_sum > {1'b0, j_end[cur]}) ? j_end[cur] : e_sum[31:0];

    wc_eff  = (workers == 5'd0) ? 5'd1 : workers;
    wc32    = (32'(wc_eff) > LANES) ? 32'(LANES) : 32'(wc_eff);
    items   = in_re - in_rs;
    lanes32 = (items < wc32) ? items : wc32;

    lane_sel = LW'(in_lane);
  end

  always_comb begin
    stat.kind        = in_kind;
    stat.job_ok      = 32'(in_job) < JOBS;
    stat.active      = f_act[cur];
    stat.prio_bad    = in_prio > PRIO_HIGH;
    stat.range_empty = in_re <= in_rs;
    stat.lane_ok     = (32'(in_lane) < LANES) && j_busy[cur][lane_sel];
    stat.finish_now  = (j_act[cur] == '0) && (err_cur || (j_next[cur] >= j_end[cur]));
    stat.total_nz    = (rc[0] != '0) || (rc[1] != '0) || (rc[2] != '0);
    stat.pri_nz      = rc[weight_at(pos)] != '0;
    stat.scan_hit    = mismatch || last_idx;
    stat.checks_ok   = f_act[cur] && !err_cur && (j_next[cur] < j_end[cur]) && fl_found;
    stat.out_free    = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      workers <= WORKERS_RESET;
      grain   <= GRAIN_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_WORKERS) begin
        workers <= cfg_data[4:0];
      end else if (cfg_index == CFG_GRAIN) begin
        grain <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_act  <= '0;
      f_q    <= '0;
      f_can  <= '0;
      f_fail <= '0;
      for (int i = 0; i < JOBS; i++) begin
        j_busy[i] <= '0;
        j_act[i]  <= '0;
      end
      for (int p = 0; p < 3; p++) begin
        rc[p] <= '0;
        lg[p] <= '0;
      end
      pos <= '0;
    end else begin
      case (cmd.op)
        CMD_LOAD: begin
          in_kind  <= item_kind;
          in_job   <= item_job;
          in_prio  <= item_prio;
          in_grp   <= item_group;
          in_rs    <= item_rs;
          in_re    <= item_re;
          in_lane  <= item_lane;
          in_cflag <= item_cflag;
          in_fflag <= item_fflag;
          cur      <= JW'(item_job);
        end
        CMD_SUBMIT: begin
          j_prio[cur]  <= in_prio;
          j_grp[cur]   <= in_grp;
          j_next[cur]  <= in_rs;
          j_end[cur]   <= in_re;
          j_lanes[cur] <= LCW'(lanes32);
          j_busy[cur]  <= '0;
          j_act[cur]   <= '0;
          f_act[cur]   <= 1'b1;
          f_q[cur]     <= 1'b0;
          f_can[cur]   <= 1'b0;
          f_fail[cur]  <= 1'b0;
        end
        CMD_COMPLETE: begin
          j_busy[cur][lane_sel] <= 1'b0;
          if (j_act[cur] != '0) begin
            j_act[cur] <= j_act[cur] - LCW'(1);
          end
          if (in_cflag) begin
            f_can[cur] <= 1'b1;
          end
          if (in_fflag) begin
            f_fail[cur] <= 1'b1;
          end
          if (err_cur || in_cflag || in_fflag) begin
            j_next[cur] <= j_end[cur];
          end
        end
        CMD_CANCEL: begin
          f_can[cur]  <= 1'b1;
          j_next[cur] <= j_end[cur];
        end
        CMD_ENQ: begin
          if (enq_ok) begin
            rl[enq_p][rc[enq_p][JW-1:0]] <= cur;
            rc[enq_p] <= rc[enq_p] + CW'(1);
            f_q[cur]  <= 1'b1;
          end
        end
        CMD_REQUEUE: begin
          if (err_cur) begin
            f_q[cur] <= 1'b0;
          end else if (enq_ok) begin
            rl[enq_p][rc[enq_p][JW-1:0]] <= cur;
            rc[enq_p] <= rc[enq_p] + CW'(1);
            f_q[cur]  <= 1'b1;
          end
        end
        CMD_FINISH: begin
          f_act[cur]  <= 1'b0;
          f_q[cur]    <= 1'b0;
          f_can[cur]  <= 1'b0;
          f_fail[cur] <= 1'b0;
          j_busy[cur] <= '0;
          j_act[cur]  <= '0;
          res_kind    <= RES_DONE;
          res_job     <= 3'(cur);
          res_b       <= '0;
          res_e       <= '0;
          res_lane    <= '0;
          res_status  <= err_cur;
        end
        CMD_PRI: begin
          pos      <= (pos == 3'(CYCLE_LEN - 1)) ? 3'd0 : pos + 3'd1;
          sel_p    <= weight_at(pos);
          scan_idx <= '0;
        end
        CMD_SCAN: begin
          if (!mismatch) begin
            scan_idx <= last_idx ? '0 : scan_idx + JW'(1);
          end
        end
        CMD_PICK: begin
          cur         <= entry;
          f_q[entry]  <= 1'b0;
          lg[sel_p]   <= r_grp;
        end
        CMD_GRANT: begin
          j_busy[cur][fl] <= 1'b1;
          j_act[cur]      <= j_act[cur] + LCW'(1);
          j_next[cur]     <= e_min;
          res_kind        <= RES_GRANT;
          res_job         <= 3'(cur);
          res_b           <= j_next[cur];
          res_e           <= e_min;
          res_lane        <= 4'(fl);
          res_status      <= 1'b0;
        end
        CMD_NO_WORK: begin
          res_kind   <= RES_NO_WORK;
          res_job    <= '0;
          res_b      <= '0;
          res_e      <= '0;
          res_lane   <= '0;
          res_status <= 1'b0;
        end
        CMD_DONE_ERR, CMD_DONE_OK: begin
          res_kind   <= RES_DONE;
          res_job    <= in_job;
          res_b      <= '0;
          res_e      <= '0;
          res_lane   <= '0;
          res_status <= (cmd.op == CMD_DONE_ERR);
        end
        default: begin
        end
      endcase
      if (rm_en) begin
        for (int i = 0; i < JOBS - 1; i++) begin
          if (JW'(i) >= rm_k) begin
            rl[rm_p][i] <= rl[rm_p][i + 1];
          end
        end
        rc[rm_p] <= rc[rm_p] - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == CMD_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == CMD_EMIT) begin
      out_kind   <= res_kind;
      out_job    <= res_job;
      out_b      <= res_b;
      out_e      <= res_e;
      out_lane   <= res_lane;
      out_status <= res_status;
    end
  end

  `WPCD_ASSERT_IMP(a_pos_range, 1'b1, pos < 3'(CYCLE_LEN))
  `WPCD_ASSERT_IMP(a_count_bound, 1'b1, (rc[0] <= CW'(JOBS)) && (rc[1] <= CW'(JOBS)))
  `WPCD_ASSERT_IMP(a_grant_nonempty, out_valid && (out_kind == RES_GRANT), out_e > out_b)
  `WPCD_ASSERT_NEXT(a_pick_dequeues, cmd.op == CMD_PICK, !f_q[cur])

endmodule

// ===== hw/rtl/weighted_priority_chunk_dispatcher_unit.sv =====
// Top level of the weighted-priority chunk dispatcher.
//
// One item is handled at a time. A submit passes decode and enqueue before the next
// transfer can be taken; a completion or cancel passes decode, requeue and finish; a
// work request steps through the weighted priority cycle to a non-empty queue, compares
// ready-queue entries against the last granted group, one entry per cycle, then picks,
// checks, enqueues and emits, going back to the priority step if the check fails. A
// request with nothing queued goes straight to emit. Results sit in an output register,
// so the next item is taken while one waits; a further result waits for it to empty.
module weighted_priority_chunk_dispatcher_unit #(
  parameter int JOBS  = wpcd_pkg::JOBS_DEFAULT,
  parameter int LANES = wpcd_pkg::LANES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // Fields from bit 0: job[2:0], priority_req[4:3], group[68:5], range_start[100:69],
  // range_end[132:101], lane[136:133], cancel_flag[137], fail_flag[138], zero fill.
  input  logic [wpcd_pkg::IN_DATA_W-1:0] s_tdata,
  // Fields from bit 0: kind[1:0].
  input  logic [1:0]                     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // Fields from bit 0: result_job[2:0], chunk_begin[34:3], chunk_end[66:35],
  // granted_lane[70:67], status[71].
  output logic [wpcd_pkg::OUT_DATA_W-1:0] m_tdata,
  // Fields from bit 0: result_kind[1:0].
  output logic [1:0]                     m_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [15:0]                    cfg_data
);
  import wpcd_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [2:0]  out_job;
  logic [31:0] out_b, out_e;
  logic [3:0]  out_lane;
  logic        out_status;

  // Register writes are always accepted.
  assign cfg_ready = 1'b1;

  wpcd_ctrl #(.JOBS(JOBS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  wpcd_datapath #(.JOBS(JOBS), .LANES(LANES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .item_kind  (s_tuser),
    .item_job   (s_tdata[2:0]),
    .item_prio  (s_tdata[4:3]),
    .item_group (s_tdata[68:5]),
    .item_rs    (s_tdata[100:69]),
    .item_re    (s_tdata[132:101]),
    .item_lane  (s_tdata[136:133]),
    .item_cflag (s_tdata[137]),
    .item_fflag (s_tdata[138]),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_job    (out_job),
    .out_b      (out_b),
    .out_e      (out_e),
    .out_lane   (out_lane),
    .out_status (out_status)
  );

  // Result transfer packing, lowest field first.
  assign m_tdata = {out_status, out_lane, out_e, out_b, out_job};

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the weighted-priority chunk dispatcher.
`timescale 1ns / 1ps

typedef struct {
  bit [1:0]  kind;
  bit [2:0]  job;
  bit [31:0] first;
  bit [31:0] last;
  bit [3:0]  lane;
  bit        status;
} dispatch_result_t;

// Tracks the dispatcher's job table and queues and holds the results still due.
class dispatch_scoreboard;
  bit [4:0]  workers;
  bit [15:0] chunk;
  bit [1:0]  prio[8];
  bit [63:0] grp[8];
  bit [31:0] next_idx[8];
  bit [31:0] end_idx[8];
  int        lane_cnt[8];
  bit [15:0] busy[8];
  int        inflight[8];
  bit        active[8];
  bit        queued[8];
  bit        cancelled[8];
  bit        failed[8];
  int        ready_q[3][8];
  int        ready_n[3];
  bit [63:0] last_grp[3];
  int        cyc_pos;
  dispatch_result_t due[$];

  function new();
    workers = wpcd_pkg::WORKERS_RESET;
    chunk   = wpcd_pkg::GRAIN_RESET;
    for (int j = 0; j < 8; j++) begin
      busy[j] = '0; inflight[j] = 0; active[j] = 0; queued[j] = 0;
      cancelled[j] = 0; failed[j] = 0;
    end
    for (int p = 0; p < 3; p++) begin
      ready_n[p] = 0; last_grp[p] = '0;
    end
    cyc_pos = 0;
  endfunction

  function void write_reg(bit [1:0] idx, bit [15:0] value);
    if (idx == wpcd_pkg::CFG_WORKERS) workers = value[4:0];
    else if (idx == wpcd_pkg::CFG_GRAIN) chunk = value;
  endfunction

  function void push(bit [1:0] k, int j, bit [31:0] b, bit [31:0] e, int l, bit s);
    dispatch_result_t r;
    r.kind = k; r.job = j[2:0]; r.first = b; r.last = e; r.lane = l[3:0]; r.status = s;
    due.insert(due.size(), r);
  endfunction

  function void remove_at(int p, int idx);
    for (int i = idx; i + 1 < ready_n[p]; i++) ready_q[p][i] = ready_q[p][i + 1];
    ready_n[p]--;
  endfunction

  function void unqueue(int j);
    int p;
    if (!queued[j]) return;
    queued[j] = 0;
    p = prio[j];
    if (p > 2) return;
    for (int i = 0; i < ready_n[p]; i++)
      if (ready_q[p][i] == j) begin
        remove_at(p, i);
        return;
      end
  endfunction

  function void requeue(int j);
    int p;
    p = prio[j];
    if (!active[j] || queued[j] || cancelled[j] || failed[j]) return;
    if (next_idx[j] >= end_idx[j] || inflight[j] >= lane_cnt[j]) return;
    if (p > 2 || ready_n[p] >= 8) return;
    ready_q[p][ready_n[p]] = j;
    ready_n[p]++;
    queued[j] = 1;
  endfunction

  // Reports done once nothing is in flight and the job is exhausted or aborted.
  function void try_retire(int j);
    bit err;
    err = cancelled[j] | failed[j];
    if (inflight[j] != 0) return;
    if (!err && next_idx[j] < end_idx[j]) return;
    unqueue(j);
    active[j] = 0; cancelled[j] = 0; failed[j] = 0;
    busy[j] = '0; inflight[j] = 0;
    push(wpcd_pkg::RES_DONE, j, 0, 0, 0, err);
  endfunction

  function int weight(int pos);
    if (pos < 4) return wpcd_pkg::PRIO_HIGH;
    if (pos < 6) return wpcd_pkg::PRIO_NORMAL;
    return wpcd_pkg::PRIO_LOW;
  endfunction

  function int pick_priority();
    int p;
    for (int a = 0; a < 7; a++) begin
      p = weight(cyc_pos);
      cyc_pos = (cyc_pos + 1) % 7;
      if (ready_n[p] != 0) return p;
    end
    for (p = 0; p < 3; p++) if (ready_n[p] != 0) return p;
    return 1;
  endfunction

  function void serve_request();
    int p, idx, j, l;
    bit [32:0] e;
    for (int guard = 0; guard <= 24; guard++) begin
      if (ready_n[0] + ready_n[1] + ready_n[2] == 0) break;
      p = pick_priority();
      if (ready_n[p] == 0) break;
      for (idx = 0; idx < ready_n[p]; idx++)
        if (grp[ready_q[p][idx]] != last_grp[p]) break;
      if (idx >= ready_n[p]) idx = 0;
      j = ready_q[p][idx];
      remove_at(p, idx);
      queued[j] = 0;
      last_grp[p] = grp[j];
      if (!active[j] || cancelled[j] || failed[j]) continue;
      if (next_idx[j] >= end_idx[j]) continue;
      for (l = 0; l < lane_cnt[j] && l < 16; l++) if (!busy[j][l]) break;
      if (l >= lane_cnt[j] || l >= 16) continue;
      busy[j][l] = 1;
      inflight[j]++;
      e = {1'b0, next_idx[j]} + ((chunk == 0) ? 33'd1 : {17'd0, chunk});
      if (e > {1'b0, end_idx[j]}) e = {1'b0, end_idx[j]};
      push(wpcd_pkg::RES_GRANT, j, next_idx[j], e[31:0], l, 0);
      next_idx[j] = e[31:0];
      requeue(j);
      return;
    end
    push(wpcd_pkg::RES_NO_WORK, 0, 0, 0, 0, 0);
  endfunction

  // Applies one accepted input transfer and queues the result it causes, if any.
  function void note_input(bit [1:0] k, int j, bit [1:0] pr, bit [63:0] g, bit [31:0] rs,
                           bit [31:0] re, int l, bit c, bit f);
    bit [31:0] items;
    int wc;
    case (k)
      wpcd_pkg::KIND_REQUEST: serve_request();
      wpcd_pkg::KIND_SUBMIT: begin
        if (active[j]) return;
        if (pr > 2) begin
          push(wpcd_pkg::RES_DONE, j, 0, 0, 0, 1);
          return;
        end
        if (re <= rs) begin
          push(wpcd_pkg::RES_DONE, j, 0, 0, 0, 0);
          return;
        end
        items = re - rs;
        wc = (workers == 0) ? 1 : workers;
        if (wc > 16) wc = 16;
        lane_cnt[j] = (items < wc) ? items : wc;
        prio[j] = pr; grp[j] = g; next_idx[j] = rs; end_idx[j] = re;
        busy[j] = '0; inflight[j] = 0;
        active[j] = 1; queued[j] = 0; cancelled[j] = 0; failed[j] = 0;
        requeue(j);
      end
      wpcd_pkg::KIND_COMPLETE: begin
        if (!active[j] || !busy[j][l]) return;
        busy[j][l] = 0;
        if (inflight[j] != 0) inflight[j]--;
        if (c) cancelled[j] = 1;
        if (f) failed[j] = 1;
        if (cancelled[j] || failed[j]) begin
          next_idx[j] = end_idx[j];
          unqueue(j);
        end else begin
          requeue(j);
        end
        try_retire(j);
      end
      default: begin
        if (!active[j]) return;
        cancelled[j] = 1;
        next_idx[j] = end_idx[j];
        unqueue(j);
        try_retire(j);
      end
    endcase
  endfunction

  // Returns an empty string when the result matches the oldest one due.
  function string check_result(dispatch_result_t got);
    dispatch_result_t w;
    if (due.size() == 0)
      return $sformatf("unexpected result kind %0d job %0d", got.kind, got.job);
    w = due.pop_front();
    if (got.kind != w.kind || got.job != w.job || got.first != w.first ||
        got.last != w.last || got.lane != w.lane || got.status != w.status)
      return $sformatf("got k%0d j%0d [%h,%h) l%0d s%0d, want k%0d j%0d [%h,%h) l%0d s%0d",
                       got.kind, got.job, got.first, got.last, got.lane, got.status,
                       w.kind, w.job, w.first, w.last, w.lane, w.status);
    return "";
  endfunction
endclass

module tb;
  import wpcd_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE      = 60;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [15:0]  cfg_data = '0;

  dispatch_scoreboard board = new();
  int  errors = 0;
  int  quiet_cycles = 0;
  bit  busy_mode = 0;   // When set, neither side inserts idle cycles.
  int  sink_stall = 0;

  weighted_priority_chunk_dispatcher_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report(input string msg);
    $display("tb: mismatch: %s", msg);
    errors++;
  endtask

  // Mostly back-to-back, sometimes a short pause, now and then a long pause.
  function automatic int idle_len();
    int r;
    if (busy_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: checks each transfer and drives tready with random stalls.
  always @(posedge clk) begin
    dispatch_result_t got;
    string msg;
    if (!rst && m_tvalid && m_tready) begin
      got.kind   = m_tuser;
      got.job    = m_tdata[2:0];
      got.first  = m_tdata[34:3];
      got.last   = m_tdata[66:35];
      got.lane   = m_tdata[70:67];
      got.status = m_tdata[71];
      msg = board.check_result(got);
      if (msg != "") report(msg);
    end
    if (sink_stall > 0) begin
      sink_stall--;
      m_tready <= 1'b0;
    end else begin
      sink_stall = idle_len();
      m_tready <= (sink_stall == 0);
    end
  end

  // Any transfer on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  // Sends one item; returns once its transfer has taken place.
  task automatic send(input bit [1:0] k, input int j, input bit [1:0] pr, input bit [63:0] g,
                      input bit [31:0] rs, input bit [31:0] re, input int l, input bit c,
                      input bit f);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= k;
    s_tdata  <= {5'd0, f, c, l[3:0], re, rs, g, pr, j[2:0]};
    do @(posedge clk); while (!s_tready);
    board.note_input(k, j, pr, g, rs, re, l, c, f);
  endtask

  task automatic request();
    send(KIND_REQUEST, $urandom_range(0, 7), 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic submit(input int j, input bit [1:0] pr, input bit [63:0] g,
                        input bit [31:0] rs, input bit [31:0] re);
    send(KIND_SUBMIT, j, pr, g, rs, re, 0, 0, 0);
  endtask

  // Waits until every result due has arrived and any trailing work has drained.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input bit [1:0] idx, input bit [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, value);
    cfg_valid <= 1'b0;
  endtask

  // Groups are drawn mostly from a few tags so that the group rotation matters.
  function automatic bit [63:0] pick_group();
    case ($urandom_range(0, 5))
      0: return 64'd0;
      1: return 64'd1;
      2: return 64'd2;
      3: return {$urandom, $urandom};
      default: return 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
  endfunction

  task automatic random_submit();
    bit [31:0] rs, re;
    bit [1:0]  pr;
    int r;
    pr = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    r = $urandom_range(0, 9);
    rs = (r < 5) ? $urandom_range(0, 200) : (r < 8) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 40);
    r = $urandom_range(0, 19);
    if (r == 0) re = rs;
    else if (r == 1) re = $urandom;
    else re = rs + $urandom_range(1, 40);
    if (r > 1 && re < rs) re = 32'hFFFF_FFFF;
    submit($urandom_range(0, 7), pr, pick_group(), rs, re);
  endtask

  // Mostly completes a chunk that is really in flight; otherwise a stray one.
  task automatic random_complete();
    int j, l, start;
    bit c, f;
    j = -1;
    start = $urandom_range(0, 7);
    for (int i = 0; i < 8; i++)
      if (j < 0 && board.active[(start + i) % 8] && board.busy[(start + i) % 8] != 0)
        j = (start + i) % 8;
    c = ($urandom_range(0, 19) == 0);
    f = ($urandom_range(0, 19) == 0);
    if (j < 0 || $urandom_range(0, 9) == 0) begin
      send(KIND_COMPLETE, $urandom_range(0, 7), 0, 0, 0, 0, $urandom_range(0, 15), c, f);
    end else begin
      start = $urandom_range(0, 15);
      l = start;
      for (int i = 0; i < 16; i++)
        if (board.busy[j][(start + i) % 16]) l = (start + i) % 16;
      send(KIND_COMPLETE, j, 0, 0, 0, 0, l, c, f);
    end
  endtask

  task automatic random_phase(input int count);
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 22) random_submit();
      else if (r < 62) request();
      else if (r < 93) random_complete();
      else send(KIND_CANCEL, $urandom_range(0, 7), 0, 0, 0, 0, 0, 0, 0);
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset settings.
    request();                                              // nothing ready
    submit(0, 2'd3, 64'd5, 0, 10);                          // bad priority
    submit(1, PRIO_LOW, 64'd5, 32'd20, 32'd20);             // empty range
    submit(1, PRIO_LOW, 64'd5, 32'd30, 32'd10);             // reversed range
    submit(2, PRIO_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    submit(3, PRIO_HIGH, 64'd0, 0, 9);
    submit(4, PRIO_NORMAL, 64'd7, 100, 103);
    submit(5, PRIO_LOW, 64'd7, 200, 201);
    submit(3, PRIO_LOW, 64'd9, 0, 5);                       // slot already busy
    repeat (8) request();
    send(KIND_COMPLETE, 3, 0, 0, 0, 0, 15, 0, 0);           // stray lane
    send(KIND_COMPLETE, 5, 0, 0, 0, 0, 0, 0, 0);            // low job finishes
    send(KIND_COMPLETE, 2, 0, 0, 0, 0, 0, 1, 0);            // cancelled chunk
    send(KIND_CANCEL, 2, 0, 0, 0, 0, 0, 0, 0);              // repeated cancel
    send(KIND_COMPLETE, 3, 0, 0, 0, 0, 1, 0, 1);            // failed chunk
    send(KIND_CANCEL, 4, 0, 0, 0, 0, 0, 0, 0);
    send(KIND_CANCEL, 6, 0, 0, 0, 0, 0, 0, 0);              // idle slot
    drain();

    random_phase(130);
    write_reg(CFG_WORKERS, 16'd0);
    write_reg(CFG_GRAIN, 16'd0);
    busy_mode = 1;
    random_phase(110);
    busy_mode = 0;
    write_reg(CFG_WORKERS, 16'hFFFF);
    write_reg(CFG_GRAIN, 16'hFFFF);
    random_phase(110);
    write_reg(CFG_WORKERS, 16'd1);
    write_reg(CFG_GRAIN, 16'd1);
    random_phase(130);
    write_reg(CFG_WORKERS, 16'd16);
    write_reg(CFG_GRAIN, 16'd3);
    random_phase(130);
    write_reg(CFG_WORKERS, 16'd5);
    write_reg(CFG_GRAIN, 16'd7);
    random_phase(130);

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// ===== weighted_priority_chunk_dispatcher_unit.f =====
+incdir+hw/rtl
hw/rtl/wpcd_pkg.sv
hw/rtl/wpcd_ctrl.sv
hw/rtl/wpcd_datapath.sv
hw/rtl/weighted_priority_chunk_dispatcher_unit.sv
tb/sv/tb.sv
